### hdl/assert_macros.svh
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check under a clock, quiet while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check under a clock, live during reset as well.
`define ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NORST(lbl, clk, prop)

`endif

`endif

### hdl/tgaup_pkg.sv
`timescale 1ns / 1ps

package tgaup_pkg;

    localparam int OUT_BYTES_PER_PIXEL = 4;
    localparam int HEADER_BYTES        = 18;
    localparam int ADDR_W              = 34;
    localparam int TDATA_IN_W          = 8;
    localparam int TDATA_OUT_W         = 136;

    typedef enum logic [1:0] {
        KIND_PIXEL,
        KIND_HEADER,
        KIND_REJECT_MAP,
        KIND_BAD_DEPTH
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [15:0]        column;
        logic [15:0]        row;
        logic [ADDR_W-1:0]  out_address;
        logic               last_pixel;
        logic [15:0]        image_width;
        logic [15:0]        image_height;
        logic               type_warning;
    } t_result;

endpackage

### hdl/tga_uncompressed_pixel_unpacker_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Unpacks an uncompressed truecolor TGA file fed one byte per request and
// returns one request per pixel (RGBA, column, row, output byte address) plus
// one status request when the 18-byte header completes. The core takes one
// byte every cycle while the output does not stall; a byte passes an input
// register and the parse logic and lands in the result register. Sustained
// rate is set by the single result register, which frees as soon as the
// downstream side takes it; a stalled output holds the input register and
// then drops tready.
module tga_uncompressed_pixel_unpacker_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [7:0] data_byte
    input  logic [tgaup_pkg::TDATA_IN_W-1:0]     i_s_axis_tdata,
    // [0] start_of_file
    input  logic                                 i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [47:32] column,
    // [63:48] row, [97:64] out_address, [113:98] image_width,
    // [129:114] image_height, [130] type_warning, [135:131] zero
    output logic [tgaup_pkg::TDATA_OUT_W-1:0]    o_m_axis_tdata,
    // [1:0] kind
    output logic [1:0]                           o_m_axis_tuser,
    // last_pixel
    output logic                                 o_m_axis_tlast
);
    import tgaup_pkg::*;

    logic       r_in_valid;
    logic       r_in_sof;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       w_out_adv;
    logic       w_proc;
    logic       w_res_valid;
    t_result    w_res;

    assign w_out_adv       = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_out_adv;
    assign w_proc          = r_in_valid && w_out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_sof  <= i_s_axis_tuser;
            r_in_byte <= i_s_axis_tdata;
        end
    end

    tgaup_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_proc),
        .i_sof       (r_in_sof),
        .i_byte      (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= w_proc && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last_pixel;
    assign o_m_axis_tdata  = {5'b00000, r_out.type_warning, r_out.image_height,
                              r_out.image_width, r_out.out_address, r_out.row,
                              r_out.column, r_out.alpha, r_out.blue, r_out.green,
                              r_out.red};

    `ASSERT_CLK(a_status_no_pixel_fields, i_clk, i_rst_n,
        r_out_valid && r_out.kind != KIND_PIXEL |-> r_out.column == 16'd0 &&
        r_out.row == 16'd0 && r_out.out_address == '0 && !r_out.last_pixel)
    `ASSERT_CLK(a_pixel_addr_aligned, i_clk, i_rst_n,
        r_out_valid && r_out.kind == KIND_PIXEL |-> r_out.out_address[1:0] == 2'b00)
    `ASSERT_CLK(a_stall_only_when_full, i_clk, i_rst_n,
        !o_s_axis_tready |-> r_in_valid && r_out_valid && !i_m_axis_tready)
    `ASSERT_NORST(a_reset_empties, i_clk, !i_rst_n |=> !r_in_valid && !r_out_valid)

endmodule

### hdl/tgaup_parser.sv
`timescale 1ns / 1ps

module tgaup_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_sof,
    input  logic [7:0]          i_byte,
    output logic                o_res_valid,
    output tgaup_pkg::t_result  o_res
);
    import tgaup_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_IDSKIP,
        PH_PIXELS,
        PH_DONE
    } t_phase;

    localparam logic [4:0] HB_ID_LEN    = 5'd0;
    localparam logic [4:0] HB_MAP_TYPE  = 5'd1;
    localparam logic [4:0] HB_IMG_TYPE  = 5'd2;
    localparam logic [4:0] HB_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HB_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HB_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HB_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HB_DEPTH     = 5'd16;
    localparam logic [4:0] HB_LAST      = 5'(HEADER_BYTES - 1);

    localparam logic [7:0] IMG_TYPE_TRUECOLOR = 8'd2;
    localparam logic [7:0] DEPTH_15 = 8'd15;
    localparam logic [7:0] DEPTH_16 = 8'd16;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    localparam logic [ADDR_W-1:0] ADDR_STEP = ADDR_W'(OUT_BYTES_PER_PIXEL);

    function automatic logic [2:0] bytes_per_pixel(input logic [7:0] d);
        logic [2:0] n;
        case (d)
            DEPTH_15: n = 3'd2;
            DEPTH_16: n = 3'd2;
            DEPTH_24: n = 3'd3;
            DEPTH_32: n = 3'd4;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

    t_phase             r_phase,  n_phase;
    logic [4:0]         r_hcount, n_hcount;
    logic [7:0]         r_id,     n_id;
    logic               r_map,    n_map;
    logic               r_warn,   n_warn;
    logic [15:0]        r_width,  n_width;
    logic [15:0]        r_height, n_height;
    logic [7:0]         r_depth,  n_depth;
    logic [1:0]         r_bphase, n_bphase;
    logic [23:0]        r_gather, n_gather;
    logic [15:0]        r_col,    n_col;
    logic [15:0]        r_row,    n_row;
    logic [ADDR_W-1:0]  r_addr,   n_addr;

    logic [2:0]         w_need;
    logic [16:0]        w_col_inc;
    logic [16:0]        w_row_inc;
    logic               w_last;
    logic [15:0]        w_word;
    logic [7:0]         w_red, w_green, w_blue, w_alpha;
    logic               w_enter;

    assign w_need    = bytes_per_pixel(r_depth);
    assign w_col_inc = {1'b0, r_col} + 17'd1;
    assign w_row_inc = {1'b0, r_row} + 17'd1;
    assign w_last    = (w_col_inc == {1'b0, r_width}) && (w_row_inc == {1'b0, r_height});
    assign w_word    = {i_byte, r_gather[7:0]};

    always_comb begin
        if (w_need == 3'd2) begin
            w_red   = {3'b000, w_word[14:10]};
            w_green = {3'b000, w_word[9:5]};
            w_blue  = {3'b000, w_word[4:0]};
            if (r_depth == DEPTH_16) begin
                w_alpha = w_word[15] ? 8'hFF : 8'h00;
            end else begin
                w_alpha = 8'hFF;
            end
        end else if (w_need == 3'd3) begin
            w_red   = r_gather[7:0];
            w_green = r_gather[15:8];
            w_blue  = i_byte;
            w_alpha = 8'hFF;
        end else begin
            w_red   = r_gather[7:0];
            w_green = r_gather[15:8];
            w_blue  = r_gather[23:16];
            w_alpha = i_byte;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_hcount    = r_hcount;
        n_id        = r_id;
        n_map       = r_map;
        n_warn      = r_warn;
        n_width     = r_width;
        n_height    = r_height;
        n_depth     = r_depth;
        n_bphase    = r_bphase;
        n_gather    = r_gather;
        n_col       = r_col;
        n_row       = r_row;
        n_addr      = r_addr;
        w_enter     = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.kind  = KIND_PIXEL;

        if (i_en) begin
            if (i_sof) begin
                n_phase  = PH_HEADER;
                n_hcount = 5'd1;
                n_id     = i_byte;
                n_map    = 1'b0;
                n_warn   = 1'b0;
                n_width  = '0;
                n_height = '0;
                n_depth  = '0;
                n_bphase = '0;
                n_gather = '0;
                n_col    = '0;
                n_row    = '0;
                n_addr   = '0;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        n_hcount = r_hcount + 5'd1;
                        case (r_hcount)
                            HB_ID_LEN:    n_id            = i_byte;
                            HB_MAP_TYPE:  n_map           = (i_byte != 8'h00);
                            HB_IMG_TYPE:  n_warn          = (i_byte != IMG_TYPE_TRUECOLOR);
                            HB_WIDTH_LO:  n_width[7:0]    = i_byte;
                            HB_WIDTH_HI:  n_width[15:8]   = i_byte;
                            HB_HEIGHT_LO: n_height[7:0]   = i_byte;
                            HB_HEIGHT_HI: n_height[15:8]  = i_byte;
                            HB_DEPTH:     n_depth         = i_byte;
                            default: ;
                        endcase
                        if (r_hcount == HB_LAST) begin
                            o_res_valid = 1'b1;
                            if (r_map) begin
                                o_res.kind = KIND_REJECT_MAP;
                                n_phase    = PH_DONE;
                            end else if (w_need == 3'd0) begin
                                o_res.kind = KIND_BAD_DEPTH;
                                n_phase    = PH_DONE;
                            end else begin
                                o_res.kind = KIND_HEADER;
                                if (r_id != 8'd0) begin
                                    n_phase = PH_IDSKIP;
                                end else begin
                                    w_enter = 1'b1;
                                end
                            end
                        end
                    end
                    PH_IDSKIP: begin
                        n_id = r_id - 8'd1;
                        if (n_id == 8'd0) begin
                            w_enter = 1'b1;
                        end
                    end
                    PH_PIXELS: begin
                        if (w_need == 3'd0) begin
                            n_phase = PH_DONE;
                        end else if (({1'b0, r_bphase} + 3'd1) < w_need) begin
                            case (r_bphase)
                                2'd0:    n_gather[7:0]   = i_byte;
                                2'd1:    n_gather[15:8]  = i_byte;
                                default: n_gather[23:16] = i_byte;
                            endcase
                            n_bphase = r_bphase + 2'd1;
                        end else begin
                            o_res_valid       = 1'b1;
                            o_res.red         = w_red;
                            o_res.green       = w_green;
                            o_res.blue        = w_blue;
                            o_res.alpha       = w_alpha;
                            o_res.column      = r_col;
                            o_res.row         = r_row;
                            o_res.out_address = r_addr;
                            o_res.last_pixel  = w_last;
                            n_bphase          = '0;
                            n_gather          = '0;
                            n_addr            = r_addr + ADDR_STEP;
                            if (w_col_inc >= {1'b0, r_width}) begin
                                n_col = '0;
                                n_row = w_row_inc[15:0];
                            end else begin
                                n_col = w_col_inc[15:0];
                            end
                            if (w_last) begin
                                n_phase = PH_DONE;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            if (w_enter) begin
                n_bphase = '0;
                n_gather = '0;
                n_col    = '0;
                n_row    = '0;
                n_addr   = '0;
                n_phase  = (n_width == 16'd0 || n_height == 16'd0) ? PH_DONE : PH_PIXELS;
            end
        end

        o_res.image_width  = n_width;
        o_res.image_height = n_height;
        o_res.type_warning = n_warn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_hcount <= '0;
            r_id     <= '0;
            r_map    <= 1'b0;
            r_warn   <= 1'b0;
            r_width  <= '0;
            r_height <= '0;
            r_depth  <= '0;
            r_bphase <= '0;
            r_gather <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_addr   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_hcount <= n_hcount;
            r_id     <= n_id;
            r_map    <= n_map;
            r_warn   <= n_warn;
            r_width  <= n_width;
            r_height <= n_height;
            r_depth  <= n_depth;
            r_bphase <= n_bphase;
            r_gather <= n_gather;
            r_col    <= n_col;
            r_row    <= n_row;
            r_addr   <= n_addr;
        end
    end

endmodule

### tb/tga_unpack_checker.sv
`timescale 1ns / 1ps

module tga_unpack_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    input  logic                                 i_s_tready,
    // [7:0] data_byte
    input  logic [tgaup_pkg::TDATA_IN_W-1:0]     i_s_tdata,
    // [0] start_of_file
    input  logic                                 i_s_tuser,
    input  logic                                 i_m_tvalid,
    input  logic                                 i_m_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [47:32] column,
    // [63:48] row, [97:64] out_address, [113:98] image_width,
    // [129:114] image_height, [130] type_warning, [135:131] zero
    input  logic [tgaup_pkg::TDATA_OUT_W-1:0]    i_m_tdata,
    // [1:0] kind
    input  logic [1:0]                           i_m_tuser,
    input  logic                                 i_m_tlast,
    output int                                   o_fail_count,
    output int                                   o_pending
);

    localparam logic [7:0] DEPTH_15           = 8'd15;
    localparam logic [7:0] DEPTH_16           = 8'd16;
    localparam logic [7:0] DEPTH_24           = 8'd24;
    localparam logic [7:0] DEPTH_32           = 8'd32;
    localparam logic [7:0] IMG_TYPE_TRUECOLOR = 8'd2;

    localparam logic [4:0] HDR_ID_LEN   = 5'd0;
    localparam logic [4:0] HDR_MAP_TYPE = 5'd1;
    localparam logic [4:0] HDR_IMG_TYPE = 5'd2;
    localparam logic [4:0] HDR_W_LO     = 5'd12;
    localparam logic [4:0] HDR_W_HI     = 5'd13;
    localparam logic [4:0] HDR_H_LO     = 5'd14;
    localparam logic [4:0] HDR_H_HI     = 5'd15;
    localparam logic [4:0] HDR_DEPTH    = 5'd16;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_IDSKIP,
        PH_PIXELS,
        PH_DONE
    } t_phase;

    t_phase                         phase;
    logic [4:0]                     hdr_idx;
    logic [7:0]                     id_left;
    logic                           map_nz;
    logic                           warn;
    logic [15:0]                    img_w;
    logic [15:0]                    img_h;
    logic [7:0]                     depth;
    logic [1:0]                     byte_idx;
    logic [23:0]                    gather;
    logic [15:0]                    col;
    logic [15:0]                    row;
    logic [tgaup_pkg::ADDR_W-1:0]   addr;

    tgaup_pkg::t_result             pending_reports[$];
    int                             fails = 0;

    function automatic int unsigned pixel_bytes(input logic [7:0] d);
        case (d)
            DEPTH_15, DEPTH_16: return 2;
            DEPTH_24:           return 3;
            DEPTH_32:           return 4;
            default:            return 0;
        endcase
    endfunction

    task automatic clear_parser(input t_phase next_phase);
        phase    = next_phase;
        hdr_idx  = '0;
        id_left  = '0;
        map_nz   = 1'b0;
        warn     = 1'b0;
        img_w    = '0;
        img_h    = '0;
        depth    = '0;
        byte_idx = '0;
        gather   = '0;
        col      = '0;
        row      = '0;
        addr     = '0;
    endtask

    task automatic enter_pixels();
        byte_idx = '0;
        gather   = '0;
        col      = '0;
        row      = '0;
        addr     = '0;
        phase    = (img_w == 0 || img_h == 0) ? PH_DONE : PH_PIXELS;
    endtask

    task automatic take_header(input logic [7:0] b);
        tgaup_pkg::t_result res;
        case (hdr_idx)
            HDR_ID_LEN:   id_left = b;
            HDR_MAP_TYPE: map_nz = (b != 8'h00);
            HDR_IMG_TYPE: warn = (b != IMG_TYPE_TRUECOLOR);
            HDR_W_LO:     img_w[7:0] = b;
            HDR_W_HI:     img_w[15:8] = b;
            HDR_H_LO:     img_h[7:0] = b;
            HDR_H_HI:     img_h[15:8] = b;
            HDR_DEPTH:    depth = b;
            default: ;
        endcase
        hdr_idx = hdr_idx + 1'b1;
        if (int'(hdr_idx) < tgaup_pkg::HEADER_BYTES) return;
        res              = '0;
        res.image_width  = img_w;
        res.image_height = img_h;
        res.type_warning = warn;
        if (map_nz) begin
            res.kind = tgaup_pkg::KIND_REJECT_MAP;
            phase    = PH_DONE;
        end else if (pixel_bytes(depth) == 0) begin
            res.kind = tgaup_pkg::KIND_BAD_DEPTH;
            phase    = PH_DONE;
        end else begin
            res.kind = tgaup_pkg::KIND_HEADER;
            if (id_left != 0) phase = PH_IDSKIP;
            else enter_pixels();
        end
        pending_reports.push_back(res);
    endtask

    task automatic take_pixel_byte(input logic [7:0] b);
        tgaup_pkg::t_result res;
        int unsigned        need;
        logic [15:0]        word;
        need = pixel_bytes(depth);
        if (need == 0) begin
            phase = PH_DONE;
            return;
        end
        if (int'(byte_idx) + 1 < need) begin
            gather[8*byte_idx +: 8] = b;
            byte_idx = byte_idx + 1'b1;
            return;
        end
        res              = '0;
        res.kind         = tgaup_pkg::KIND_PIXEL;
        res.image_width  = img_w;
        res.image_height = img_h;
        res.type_warning = warn;
        if (need == 2) begin
            word      = {b, gather[7:0]};
            res.red   = {3'b000, word[14:10]};
            res.green = {3'b000, word[9:5]};
            res.blue  = {3'b000, word[4:0]};
            res.alpha = (depth == DEPTH_16 && !word[15]) ? 8'h00 : 8'hFF;
        end else begin
            res.red   = gather[7:0];
            res.green = gather[15:8];
            res.blue  = (need == 3) ? b : gather[23:16];
            res.alpha = (need == 3) ? 8'hFF : b;
        end
        res.column      = col;
        res.row         = row;
        res.out_address = addr;
        res.last_pixel  = (int'(col) + 1 == int'(img_w)) && (int'(row) + 1 == int'(img_h));
        pending_reports.push_back(res);
        byte_idx = '0;
        gather   = '0;
        addr     = addr + tgaup_pkg::OUT_BYTES_PER_PIXEL;
        if (int'(col) + 1 >= int'(img_w)) begin
            col = '0;
            row = row + 1'b1;
        end else begin
            col = col + 1'b1;
        end
        if (res.last_pixel) phase = PH_DONE;
    endtask

    task automatic unpack_byte(input logic sof, input logic [7:0] b);
        if (sof) clear_parser(PH_HEADER);
        case (phase)
            PH_HEADER: take_header(b);
            PH_IDSKIP: begin
                id_left = id_left - 1'b1;
                if (id_left == 0) enter_pixels();
            end
            PH_PIXELS: take_pixel_byte(b);
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d actual %0d", name, want, got);
            fails++;
        end
    endtask

    task automatic check_report();
        tgaup_pkg::t_result want;
        if (pending_reports.size() == 0) begin
            $error("unexpected request: kind %0d", i_m_tuser);
            fails++;
            return;
        end
        want = pending_reports.pop_front();
        compare_field("kind", want.kind, i_m_tuser);
        compare_field("red", want.red, i_m_tdata[7:0]);
        compare_field("green", want.green, i_m_tdata[15:8]);
        compare_field("blue", want.blue, i_m_tdata[23:16]);
        compare_field("alpha", want.alpha, i_m_tdata[31:24]);
        compare_field("column", want.column, i_m_tdata[47:32]);
        compare_field("row", want.row, i_m_tdata[63:48]);
        compare_field("out_address", want.out_address, i_m_tdata[97:64]);
        compare_field("image_width", want.image_width, i_m_tdata[113:98]);
        compare_field("image_height", want.image_height, i_m_tdata[129:114]);
        compare_field("type_warning", want.type_warning, i_m_tdata[130]);
        compare_field("last_pixel", want.last_pixel, i_m_tlast);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser(PH_IDLE);
            pending_reports.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) unpack_byte(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready) check_report();
        end
        o_pending    <= pending_reports.size();
        o_fail_count <= fails;
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic [7:0] DEPTH_15           = 8'd15;
    localparam logic [7:0] DEPTH_16           = 8'd16;
    localparam logic [7:0] DEPTH_24           = 8'd24;
    localparam logic [7:0] DEPTH_32           = 8'd32;
    localparam logic [7:0] IMG_TYPE_TRUECOLOR = 8'd2;

    localparam int RANDOM_ITEMS   = 300;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam int RX_OPEN     = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_SLOW     = 2;
    localparam int RX_PERIODIC = 3;

    localparam logic [7:0] GOOD_DEPTHS [4] = '{DEPTH_15, DEPTH_16, DEPTH_24, DEPTH_32};

    logic                                clk;
    logic                                rst_n    = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic [tgaup_pkg::TDATA_IN_W-1:0]    s_tdata  = '0;
    logic                                s_tuser  = 1'b0;
    logic                                s_tready;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [tgaup_pkg::TDATA_OUT_W-1:0]   m_tdata;
    logic [1:0]                          m_tuser;
    logic                                m_tlast;
    int                                  fail_count;
    int                                  pending;

    logic [7:0]                          file_q[$];
    int                                  burst_left = 0;
    int                                  stim_count = 0;
    bit                                  calm       = 1'b0;
    bit                                  hold_go    = 1'b0;

    tga_uncompressed_pixel_unpacker_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    tga_unpack_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int bytes_for_depth(input logic [7:0] d);
        case (d)
            DEPTH_15, DEPTH_16: return 2;
            DEPTH_24:           return 3;
            DEPTH_32:           return 4;
            default:            return 0;
        endcase
    endfunction

    task automatic send_byte(input logic sof, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_junk(input int n);
        repeat (n) send_byte(1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_file(input int n);
        for (int i = 0; i < n; i++) send_byte(i == 0, file_q[i]);
        stim_count += n;
        file_q.delete();
    endtask

    task automatic put_random(input int n);
        repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_header(input logic [7:0] id_len, input logic [7:0] map_type,
                              input logic [7:0] img_type, input logic [15:0] w,
                              input logic [15:0] h, input logic [7:0] depth);
        file_q.push_back(id_len);
        file_q.push_back(map_type);
        file_q.push_back(img_type);
        put_random(9);
        file_q.push_back(w[7:0]);
        file_q.push_back(w[15:8]);
        file_q.push_back(h[7:0]);
        file_q.push_back(h[15:8]);
        file_q.push_back(depth);
        put_random(1);
    endtask

    task automatic random_file(input bit big);
        int         pick;
        int         w;
        int         h;
        int         bpp;
        logic [7:0] id_len;
        logic [7:0] map_type;
        logic [7:0] img_type;
        logic [7:0] depth;
        pick     = big ? 99 : $urandom_range(0, 99);
        calm     = big || ($urandom_range(0, 3) == 0);
        id_len   = ($urandom_range(0, 9) < 7) ? 8'd0 :
                   ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) :
                   8'($urandom_range(1, 4));
        map_type = 8'h00;
        img_type = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                   IMG_TYPE_TRUECOLOR;
        depth    = GOOD_DEPTHS[$urandom_range(0, 3)];
        w        = $urandom_range(1, 4);
        h        = $urandom_range(1, 3);
        if (big) begin
            w     = 8;
            h     = 6;
            depth = DEPTH_32;
        end
        if (pick < 8) begin
            map_type = 8'($urandom_range(1, 255));
        end else if (pick < 16) begin
            do depth = 8'($urandom_range(0, 255)); while (bytes_for_depth(depth) != 0);
        end else if (pick < 22) begin
            if ($urandom_range(0, 1) == 1) w = 0;
            else h = 0;
        end else if (pick < 32) begin
            w = $urandom_range(0, 65535);
            h = $urandom_range(0, 65535);
        end
        bpp = bytes_for_depth(depth);
        put_header(id_len, map_type, img_type, 16'(w), 16'(h), depth);
        put_random(int'(id_len));
        if (pick >= 22 && pick < 32) begin
            put_random(bpp * $urandom_range(0, 4) + $urandom_range(0, bpp - 1));
            send_file($urandom_range(1, file_q.size()));
        end else begin
            if (pick >= 16) put_random(w * h * bpp);
            send_file(file_q.size());
            if (pick < 22 || $urandom_range(0, 3) == 0) send_junk($urandom_range(1, 4));
        end
    endtask

    initial begin : rx_pace
        int mode;
        int mode_left;
        int hold_left;
        bit held;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_go && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(RX_OPEN, RX_PERIODIC);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:  m_tready <= 1'b1;
                    RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
                    RX_SLOW:  m_tready <= ($urandom_range(0, 3) == 0);
                    default:  m_tready <= (mode_left % 3 == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drop: bytes before any start of file
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hFF);

        put_header(8'd0, 8'd0, IMG_TYPE_TRUECOLOR, 16'd2, 16'd1, DEPTH_24);
        file_q.push_back(8'h00);
        file_q.push_back(8'hFF);
        file_q.push_back(8'h80);
        file_q.push_back(8'hFF);
        file_q.push_back(8'h00);
        file_q.push_back(8'h7F);
        send_file(file_q.size());

        // colour map rejection wins over a bad depth
        put_header(8'd0, 8'd1, IMG_TYPE_TRUECOLOR, 16'd1, 16'd1, 8'd0);
        send_file(file_q.size());
        send_junk(2);

        put_header(8'd0, 8'd0, IMG_TYPE_TRUECOLOR, 16'd1, 16'd1, 8'd8);
        send_file(file_q.size());

        put_header(8'd2, 8'd0, 8'd3, 16'd1, 16'd1, DEPTH_16);
        put_random(2);
        file_q.push_back(8'hFF);
        file_q.push_back(8'hFF);
        send_file(file_q.size());
        send_junk(2);

        put_header(8'd0, 8'd0, IMG_TYPE_TRUECOLOR, 16'd1, 16'd2, DEPTH_15);
        file_q.push_back(8'h00);
        file_q.push_back(8'h80);
        file_q.push_back(8'hFF);
        file_q.push_back(8'h7F);
        send_file(file_q.size());

        put_header(8'd0, 8'd0, IMG_TYPE_TRUECOLOR, 16'd1, 16'd1, DEPTH_32);
        put_random(4);
        send_file(file_q.size());

        put_header(8'd1, 8'd0, IMG_TYPE_TRUECOLOR, 16'd0, 16'd5, DEPTH_24);
        put_random(1);
        send_file(file_q.size());
        send_junk(3);

        // cut short mid-pixel, then inside the header
        put_header(8'd0, 8'd0, 8'hFF, 16'hFFFF, 16'hFFFF, DEPTH_16);
        put_random(11);
        send_file(file_q.size());
        put_header(8'd0, 8'd0, IMG_TYPE_TRUECOLOR, 16'd1, 16'd1, DEPTH_24);
        send_file(7);

        stim_count = 0;
        hold_go    = 1'b1;
        random_file(1'b1);
        while (stim_count < RANDOM_ITEMS) random_file(1'b0);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/tgaup_pkg.sv
hdl/tgaup_parser.sv
hdl/tga_uncompressed_pixel_unpacker_core.sv
tb/tga_unpack_checker.sv
tb/tb.sv
